FILE: rtl/core/polygon_area_vertex_mean_top_macros.svh
// Assertion macros for the polygon area and vertex mean block.
// Used by polygon_area_vertex_mean_top; depends on nothing else.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef POLYGON_AREA_VERTEX_MEAN_TOP_MACROS_SVH
`define POLYGON_AREA_VERTEX_MEAN_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every sampled edge.
`define PAVM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define PAVM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds at the edge after the antecedent.
`define PAVM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define PAVM_ASSERT_ALWAYS(lbl, cond, msg)
`define PAVM_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PAVM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/core/pavm_pkg.sv
// Shared types and constants for the polygon area and vertex mean block.
// Used by every module in rtl/core; depends on nothing.
package pavm_pkg;

  // Fixed field widths.
  localparam int COORD_W     = 16;
  localparam int AREA_W      = 42;
  localparam int CENTRE_W    = 16;
  localparam int COUNT_OUT_W = 11;

  // Fewest vertices that enclose any area.
  localparam int MIN_AREA_COUNT = 3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_P1,
    ST_EDGE_P2,
    ST_EDGE_P3,
    ST_UPDATE,
    ST_CLOSE_P1,
    ST_CLOSE_P2,
    ST_CLOSE_P3,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DONE
  } pavm_state_t;

  // Control of the cross product accumulator.
  typedef struct packed {
    logic acc_add;
    logic acc_sub;
    logic acc_clr;
  } cross_ctl_t;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/pavm_cross.sv
// Shared multiplier and shoelace accumulator.
// Depends on pavm_pkg for the coordinate width and the control struct.
module pavm_cross #(
  parameter int CROSS_W = 51
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [pavm_pkg::COORD_W-1:0] op_a,
  input  logic signed [pavm_pkg::COORD_W-1:0] op_b,
  input  pavm_pkg::cross_ctl_t               ctl,
  output logic signed [CROSS_W-1:0]          acc
);

  localparam int PROD_W = 2 * pavm_pkg::COORD_W;

  logic signed [PROD_W-1:0]  prod_r;
  logic signed [CROSS_W-1:0] prod_ext;
  logic signed [CROSS_W-1:0] acc_r;
  logic signed [CROSS_W-1:0] acc_nxt;

  // The product register always follows the operands, in the cycle after they appear.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  // Clear the sum, or add or subtract the previous cycle's product.
  always_comb begin
    prod_ext = CROSS_W'(prod_r);
    acc_nxt  = acc_r;
    if (ctl.acc_clr) begin
      acc_nxt = '0;
    end else if (ctl.acc_add) begin
      acc_nxt = acc_r + prod_ext;
    end else if (ctl.acc_sub) begin
      acc_nxt = acc_r - prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: rtl/core/pavm_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on pavm_pkg for the status struct.
module pavm_div #(
  parameter int SUM_W = 27,
  parameter int CNT_W = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output pavm_pkg::div_stat_t     stat,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic              neg_r;
  logic [STEP_W-1:0] steps_r;
  logic              busy_r;
  logic              done_r;
  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // Magnitude of the dividend; the sign is put back at the end.
  assign mag = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

  // One restoring step: bring down the next bit and try the divisor.
  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        steps_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        steps_r <= steps_r - 1'b1;
        if (steps_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Data registers.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

FILE: rtl/core/polygon_area_vertex_mean_top.sv
// Channel  | Direction | Handshake           | Payload
// in       | input     | in_valid / in_stall | in_vertex_x, in_vertex_y, in_last_vertex
// out      | output    | out_valid/out_stall | out_area_twice, out_centre_x, out_centre_y,
//          |           |                     | out_vertex_count, out_overflow
//
// Top level of the shoelace polygon area and vertex mean block.
// Depends on pavm_pkg, pavm_cross, pavm_div and the macros header.
// Each vertex runs the edge states (the first vertex or an ignored one skips them): one shared
// multiplier forms the two products of each cross term in turn.
// The last vertex then runs the closing edge, followed by two divisions on the shared divider,
// one for each mean, and the result is then loaded into the output register.
// Reset is synchronous, active low, and clears the sequencer and all sums.
// A waiting result sits in the output register while the next polygon is taken;
// only a second result waits for out_stall to drop.
`include "polygon_area_vertex_mean_top_macros.svh"

module polygon_area_vertex_mean_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pavm_pkg::COORD_W-1:0]  in_vertex_x,
  input  logic signed [pavm_pkg::COORD_W-1:0]  in_vertex_y,
  input  logic                                 in_last_vertex,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pavm_pkg::AREA_W-1:0]          out_area_twice,
  output logic signed [pavm_pkg::CENTRE_W-1:0] out_centre_x,
  output logic signed [pavm_pkg::CENTRE_W-1:0] out_centre_y,
  output logic [pavm_pkg::COUNT_OUT_W-1:0]     out_vertex_count,
  output logic                                 out_overflow
);

  localparam int COORD_W     = pavm_pkg::COORD_W;
  localparam int CNT_W       = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W       = COORD_W + CNT_W;
  localparam int CROSS_RAW_W = 2 * COORD_W + CNT_W + 2;
  localparam int CROSS_W     = (CROSS_RAW_W > pavm_pkg::AREA_W) ? CROSS_RAW_W
                                                                 : pavm_pkg::AREA_W + 1;

  pavm_pkg::pavm_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0]  vx_r, vy_r;
  logic                       last_r;
  logic signed [COORD_W-1:0]  first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [SUM_W-1:0]    sum_x_r, sum_y_r;
  logic [CNT_W-1:0]           count_r;
  logic                       too_many_r;
  logic signed [SUM_W-1:0]    cx_r, cy_r;

  logic                       accept;
  logic                       room;
  logic                       load_out;
  logic                       out_valid_r;
  logic                       in_div;
  logic signed [COORD_W-1:0]  op_a, op_b;
  pavm_pkg::cross_ctl_t       cross_ctl;
  logic signed [CROSS_W-1:0]  cross_sum;
  logic [CROSS_W-1:0]         cross_mag;
  logic                       div_start;
  logic signed [SUM_W-1:0]    div_dividend;
  pavm_pkg::div_stat_t        div_stat;
  logic signed [SUM_W-1:0]    div_quotient;
  logic [31:0]                count_wide;

  assign accept = in_valid && !in_stall;
  assign room   = (count_r < CNT_W'(MAX_VERTICES));

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pavm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, multiplier operands and unit controls.
  always_comb begin
    state_nxt    = state_r;
    op_a         = prev_x_r;
    op_b         = vy_r;
    cross_ctl    = '0;
    div_start    = 1'b0;
    div_dividend = sum_x_r;
    load_out     = 1'b0;
    case (state_r)
      pavm_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (room && (count_r != '0)) begin
            state_nxt = pavm_pkg::ST_EDGE_P1;
          end else begin
            state_nxt = pavm_pkg::ST_UPDATE;
          end
        end
      end
      pavm_pkg::ST_EDGE_P1: begin
        op_a      = prev_x_r;
        op_b      = vy_r;
        state_nxt = pavm_pkg::ST_EDGE_P2;
      end
      pavm_pkg::ST_EDGE_P2: begin
        op_a              = vx_r;
        op_b              = prev_y_r;
        cross_ctl.acc_add = 1'b1;
        state_nxt         = pavm_pkg::ST_EDGE_P3;
      end
      pavm_pkg::ST_EDGE_P3: begin
        cross_ctl.acc_sub = 1'b1;
        state_nxt         = pavm_pkg::ST_UPDATE;
      end
      pavm_pkg::ST_UPDATE: begin
        state_nxt = last_r ? pavm_pkg::ST_CLOSE_P1 : pavm_pkg::ST_IDLE;
      end
      pavm_pkg::ST_CLOSE_P1: begin
        op_a      = prev_x_r;
        op_b      = first_y_r;
        state_nxt = pavm_pkg::ST_CLOSE_P2;
      end
      pavm_pkg::ST_CLOSE_P2: begin
        op_a              = first_x_r;
        op_b              = prev_y_r;
        cross_ctl.acc_add = 1'b1;
        state_nxt         = pavm_pkg::ST_CLOSE_P3;
      end
      pavm_pkg::ST_CLOSE_P3: begin
        cross_ctl.acc_sub = 1'b1;
        div_start         = 1'b1;
        div_dividend      = sum_x_r;
        state_nxt         = pavm_pkg::ST_DIV_X;
      end
      pavm_pkg::ST_DIV_X: begin
        div_dividend = sum_y_r;
        if (div_stat.done) begin
          div_start = 1'b1;
          state_nxt = pavm_pkg::ST_DIV_Y;
        end
      end
      pavm_pkg::ST_DIV_Y: begin
        if (div_stat.done) begin
          state_nxt = pavm_pkg::ST_DONE;
        end
      end
      pavm_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out          = 1'b1;
          cross_ctl.acc_clr = 1'b1;
          state_nxt         = pavm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pavm_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != pavm_pkg::ST_IDLE);
  assign in_div   = state_r inside {pavm_pkg::ST_DIV_X, pavm_pkg::ST_DIV_Y};

  // Latch the accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      vx_r   <= in_vertex_x;
      vy_r   <= in_vertex_y;
      last_r <= in_last_vertex;
    end
  end

  // Vertex bookkeeping: first and previous vertex, sums and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r  <= '0;
      first_y_r  <= '0;
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      count_r    <= '0;
      too_many_r <= 1'b0;
    end else if (load_out) begin
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      count_r    <= '0;
      too_many_r <= 1'b0;
    end else if (state_r == pavm_pkg::ST_UPDATE) begin
      if (room) begin
        if (count_r == '0) begin
          first_x_r <= vx_r;
          first_y_r <= vy_r;
        end
        prev_x_r <= vx_r;
        prev_y_r <= vy_r;
        sum_x_r  <= sum_x_r + SUM_W'(vx_r);
        sum_y_r  <= sum_y_r + SUM_W'(vy_r);
        count_r  <= count_r + 1'b1;
      end else begin
        too_many_r <= 1'b1;
      end
    end
  end

  // Capture each mean as the divider finishes it.
  always_ff @(posedge clk) begin
    if (div_stat.done && (state_r == pavm_pkg::ST_DIV_X)) begin
      cx_r <= div_quotient;
    end
    if (div_stat.done && (state_r == pavm_pkg::ST_DIV_Y)) begin
      cy_r <= div_quotient;
    end
  end

  pavm_cross #(
    .CROSS_W (CROSS_W)
  ) u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .op_a  (op_a),
    .op_b  (op_b),
    .ctl   (cross_ctl),
    .acc   (cross_sum)
  );

  pavm_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  // Absolute shoelace sum and widened count for the result fields.
  assign cross_mag  = cross_sum[CROSS_W-1] ? CROSS_W'(-cross_sum) : CROSS_W'(cross_sum);
  assign count_wide = 32'(count_r);

  // Output register; it holds its item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (count_r < CNT_W'(pavm_pkg::MIN_AREA_COUNT)) begin
        out_area_twice <= '0;
      end else begin
        out_area_twice <= cross_mag[pavm_pkg::AREA_W-1:0];
      end
      out_centre_x     <= cx_r[pavm_pkg::CENTRE_W-1:0];
      out_centre_y     <= cy_r[pavm_pkg::CENTRE_W-1:0];
      out_vertex_count <= count_wide[pavm_pkg::COUNT_OUT_W-1:0];
      out_overflow     <= too_many_r;
    end
  end

  assign out_valid = out_valid_r;

  // Checks on the sequencer and the shared units.
  `PAVM_ASSERT_NEXT(a_stall_after_accept, accept, in_stall, "no stall after an item was taken")
  `PAVM_ASSERT_IMPLY(a_div_nonzero, div_start, count_r != '0, "divider started with zero count")
  `PAVM_ASSERT_IMPLY(a_done_in_div, div_stat.done, in_div, "divider done outside a division")
  `PAVM_ASSERT_IMPLY(a_too_many_full, too_many_r, !room, "overflow flagged below full count")

endmodule
